// File: rtl/core/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// shared concurrent assertion macros, sampled on clk, held off in rst
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define NWD_ASSERT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("nwd assertion failed");

// next-cycle implication
`define NWD_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("nwd assertion failed");

`endif

// File: rtl/core/nwd_pkg.sv
// ----------------------------------------------------------------------------
// nwd_pkg
// shared constants and types of the nearest wall distance core
// ----------------------------------------------------------------------------
package nwd_pkg;

  localparam int MAX_WALLS  = 64;
  localparam int IDX_W      = $clog2(MAX_WALLS);
  localparam int CNT_W      = $clog2(MAX_WALLS + 1);
  localparam int DIV_STEPS  = 35;
  localparam int SQRT_STEPS = 18;
  localparam logic [16:0] DIST_MAX = 17'h1FFFF;

  localparam logic MODE_ADD   = 1'b0;
  localparam logic MODE_QUERY = 1'b1;

  typedef enum logic [3:0] {
    S_IDLE, S_RD, S_LD, S_MUL, S_SEL, S_DIV, S_UPD, S_SQI, S_SQRT, S_FIN, S_PUT
  } state_t;

  typedef enum logic [3:0] {
    ST_DXDX, ST_DYDY, ST_UXDX, ST_UYDY, ST_UXUX, ST_UYUY, ST_VXVX, ST_VYVY,
    ST_UXDY, ST_UYDX, ST_ABS, ST_C0C0, ST_C1C0, ST_C1C1, ST_DRAIN
  } mul_step_t;

  typedef struct packed {
    logic signed [17:0] a;
    logic signed [17:0] b;
  } mul_op_t;

endpackage

// File: rtl/core/nwd_if.sv
// ----------------------------------------------------------------------------
// nwd_if
// valid/ready channels for input and result beats
// ----------------------------------------------------------------------------
interface nwd_in_if;
  logic               valid;
  logic               ready;
  logic               mode;
  logic signed [15:0] ax;
  logic signed [15:0] ay;
  logic signed [15:0] bx;
  logic signed [15:0] by;
  modport source (output valid, mode, ax, ay, bx, by, input ready);
  modport sink (input valid, mode, ax, ay, bx, by, output ready);
endinterface

interface nwd_out_if;
  logic        valid;
  logic        ready;
  logic [16:0] distance;
  logic        empty_map;
  logic        add_rejected;
  modport source (output valid, distance, empty_map, add_rejected, input ready);
  modport sink (input valid, distance, empty_map, add_rejected, output ready);
endinterface

// File: rtl/core/nwd_wall_mem.sv
// ----------------------------------------------------------------------------
// nwd_wall_mem
// wall table, one write and one registered read port
// ----------------------------------------------------------------------------
module nwd_wall_mem (
  input  logic                      clk,
  input  logic                      we,
  input  logic [nwd_pkg::IDX_W-1:0] waddr,
  input  logic [63:0]               wdata,
  input  logic [nwd_pkg::IDX_W-1:0] raddr,
  output logic [63:0]               rdata
);
  import nwd_pkg::*;

  logic [63:0] mem [MAX_WALLS];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

// File: rtl/core/nwd_mul.sv
// ----------------------------------------------------------------------------
// nwd_mul
// shared signed 18x18 multiplier with registered product
// ----------------------------------------------------------------------------
module nwd_mul (
  input  logic                    clk,
  input  nwd_pkg::mul_op_t        op,
  output logic signed [35:0]      p
);
  import nwd_pkg::*;

  always_ff @(posedge clk) begin
    p <= op.a * op.b;
  end
endmodule

// File: rtl/core/nearest_wall_distance_core.sv
// ----------------------------------------------------------------------------
// nearest_wall_distance_core
// nearest wall distance over a table of segments, one shared multiplier
// ----------------------------------------------------------------------------
// channel  dir  beat contents
// in_ch    in   mode, ax, ay, bx, by (signed q8.8)
// out_ch   out  distance (q9.8), empty_map, add_rejected
//
// an add or an empty-map query goes from S_IDLE through S_PUT to the output register
// a query runs through the walls in turn: per wall one memory read,
// 14 multiplier beats and a 35-step restoring divide, then an 18-step root
// a wall whose nearest point is an endpoint skips the divide
// rst clears the wall count and the control state, the table is not cleared
// a new beat is taken while a finished result waits in the output register
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module nearest_wall_distance_core (
  input  logic clk,
  input  logic rst,
  nwd_in_if.sink    in_ch,
  nwd_out_if.source out_ch
);
  import nwd_pkg::*;

  state_t state, state_next;

  logic [CNT_W-1:0] wall_count;
  logic [IDX_W-1:0] idx;
  logic             accept, full, mem_we, last;
  logic [63:0]      rdata;

  logic signed [15:0] px, py;
  logic signed [16:0] dx, dy, ux, uy, vx, vy;
  mul_step_t          j, pj;
  mul_op_t            op;
  logic signed [35:0] p, len2, dot, e1, e2, cr, crabs;
  logic [67:0]        nn;
  logic [33:0]        rem;
  logic [34:0]        dvd, quo, best, r2, diff;
  logic               ge;
  logic [5:0]         cnt;
  logic [35:0]        sv;
  logic [20:0]        srem, nxt, trial;
  logic [17:0]        root;
  logic               ge2;

  logic        o_valid, res_empty, res_rej;
  logic [16:0] o_dist, res_dist;
  logic        o_empty, o_rej;

  assign accept = in_ch.valid && in_ch.ready;
  assign full   = (wall_count == CNT_W'(MAX_WALLS));
  assign mem_we = accept && (in_ch.mode == MODE_ADD) && !full;
  assign last   = ((CNT_W'(idx) + CNT_W'(1)) == wall_count);

  nwd_wall_mem u_mem (
    .clk   (clk),
    .we    (mem_we),
    .waddr (wall_count[IDX_W-1:0]),
    .wdata ({in_ch.by, in_ch.bx, in_ch.ay, in_ch.ax}),
    .raddr (idx),
    .rdata (rdata)
  );

  nwd_mul u_mul (
    .clk (clk),
    .op  (op),
    .p   (p)
  );

  // operand select
  assign crabs = cr[35] ? -cr : cr;
  always_comb begin
    op = '{a: '0, b: '0};
    case (j)
      ST_DXDX: op = '{a: 18'(dx), b: 18'(dx)};
      ST_DYDY: op = '{a: 18'(dy), b: 18'(dy)};
      ST_UXDX: op = '{a: 18'(ux), b: 18'(dx)};
      ST_UYDY: op = '{a: 18'(uy), b: 18'(dy)};
      ST_UXUX: op = '{a: 18'(ux), b: 18'(ux)};
      ST_UYUY: op = '{a: 18'(uy), b: 18'(uy)};
      ST_VXVX: op = '{a: 18'(vx), b: 18'(vx)};
      ST_VYVY: op = '{a: 18'(vy), b: 18'(vy)};
      ST_UXDY: op = '{a: 18'(ux), b: 18'(dy)};
      ST_UYDX: op = '{a: 18'(uy), b: 18'(dx)};
      ST_C0C0: op = '{a: {1'b0, crabs[16:0]}, b: {1'b0, crabs[16:0]}};
      ST_C1C0: op = '{a: {1'b0, crabs[33:17]}, b: {1'b0, crabs[16:0]}};
      ST_C1C1: op = '{a: {1'b0, crabs[33:17]}, b: {1'b0, crabs[33:17]}};
      default: op = '{a: '0, b: '0};
    endcase
  end

  // divide and root steps
  assign r2    = {rem, dvd[34]};
  assign ge    = (r2 >= {1'b0, len2[33:0]});
  assign diff  = r2 - {1'b0, len2[33:0]};
  assign nxt   = {srem[18:0], sv[35:34]};
  assign trial = {1'b0, root, 2'b01};
  assign ge2   = (nxt >= trial);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    in_ch.ready = (state == S_IDLE) && !rst;
    case (state)
      S_IDLE: begin
        if (accept) begin
          if (in_ch.mode == MODE_QUERY && wall_count != '0) begin
            state_next = S_RD;
          end else begin
            state_next = S_PUT;
          end
        end
      end
      S_RD:  state_next = S_LD;
      S_LD:  state_next = S_MUL;
      S_MUL: begin
        if (j == ST_DRAIN) begin
          state_next = S_SEL;
        end
      end
      S_SEL: begin
        if (len2 == '0 || dot[35] || dot > len2) begin
          state_next = last ? S_SQI : S_RD;
        end else begin
          state_next = S_DIV;
        end
      end
      S_DIV: begin
        if (cnt == 6'(DIV_STEPS - 1)) begin
          state_next = S_UPD;
        end
      end
      S_UPD: state_next = last ? S_SQI : S_RD;
      S_SQI: state_next = S_SQRT;
      S_SQRT: begin
        if (cnt == 6'(SQRT_STEPS - 1)) begin
          state_next = S_FIN;
        end
      end
      S_FIN: state_next = S_PUT;
      S_PUT: begin
        if (!o_valid || out_ch.ready) begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wall_count <= '0;
    end else if (mem_we) begin
      wall_count <= wall_count + CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    case (state)
      S_IDLE: begin
        px <= in_ch.ax;
        py <= in_ch.ay;
        idx <= '0;
        best <= '1;
        res_dist <= '0;
        res_empty <= 1'b0;
        res_rej <= 1'b0;
        if (accept && in_ch.mode == MODE_ADD) begin
          res_rej <= full;
        end else if (accept && wall_count == '0) begin
          res_dist <= DIST_MAX;
          res_empty <= 1'b1;
        end
      end
      S_LD: begin
        dx <= 17'(signed'(rdata[47:32])) - 17'(signed'(rdata[15:0]));
        dy <= 17'(signed'(rdata[63:48])) - 17'(signed'(rdata[31:16]));
        ux <= 17'(px) - 17'(signed'(rdata[15:0]));
        uy <= 17'(py) - 17'(signed'(rdata[31:16]));
        vx <= 17'(px) - 17'(signed'(rdata[47:32]));
        vy <= 17'(py) - 17'(signed'(rdata[63:48]));
        j  <= ST_DXDX;
        pj <= ST_DRAIN;
      end
      S_MUL: begin
        pj <= j;
        if (j != ST_DRAIN) begin
          j <= mul_step_t'(j + 4'd1);
        end
        case (pj)
          ST_DXDX: len2 <= p;
          ST_DYDY: len2 <= len2 + p;
          ST_UXDX: dot <= p;
          ST_UYDY: dot <= dot + p;
          ST_UXUX: e1 <= p;
          ST_UYUY: e1 <= e1 + p;
          ST_VXVX: e2 <= p;
          ST_VYVY: e2 <= e2 + p;
          ST_UXDY: cr <= p;
          ST_UYDX: cr <= cr - p;
          ST_C0C0: nn <= {32'b0, p};
          ST_C1C0: nn <= nn + ({32'b0, p} << 18);
          ST_C1C1: nn <= nn + ({32'b0, p} << 34);
          default: ;
        endcase
      end
      S_SEL: begin
        rem <= {1'b0, nn[67:35]};
        dvd <= nn[34:0];
        quo <= '0;
        cnt <= '0;
        if (len2 == '0 || dot[35]) begin
          if ({1'b0, e1[33:0]} < best) best <= {1'b0, e1[33:0]};
        end else if (dot > len2) begin
          if ({1'b0, e2[33:0]} < best) best <= {1'b0, e2[33:0]};
        end
        if (last == 1'b0 && (len2 == '0 || dot[35] || dot > len2)) begin
          idx <= idx + IDX_W'(1);
        end
      end
      S_DIV: begin
        rem <= ge ? diff[33:0] : r2[33:0];
        dvd <= dvd << 1;
        quo <= {quo[33:0], ge};
        cnt <= cnt + 6'd1;
      end
      S_UPD: begin
        if (quo < best) best <= quo;
        if (!last) idx <= idx + IDX_W'(1);
      end
      S_SQI: begin
        sv   <= {1'b0, best};
        srem <= '0;
        root <= '0;
        cnt  <= '0;
      end
      S_SQRT: begin
        srem <= ge2 ? (nxt - trial) : nxt;
        root <= {root[16:0], ge2};
        sv   <= sv << 2;
        cnt  <= cnt + 6'd1;
      end
      S_FIN: begin
        res_dist <= (root > {1'b0, DIST_MAX}) ? DIST_MAX : root[16:0];
      end
      default: ;
    endcase
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      o_valid <= 1'b0;
    end else if (state == S_PUT && (!o_valid || out_ch.ready)) begin
      o_valid <= 1'b1;
    end else if (out_ch.ready) begin
      o_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_PUT && (!o_valid || out_ch.ready)) begin
      o_dist  <= res_dist;
      o_empty <= res_empty;
      o_rej   <= res_rej;
    end
  end

  assign out_ch.valid        = o_valid;
  assign out_ch.distance     = o_dist;
  assign out_ch.empty_map    = o_empty;
  assign out_ch.add_rejected = o_rej;

  `NWD_ASSERT(a_count_max, 1'b1, wall_count <= CNT_W'(MAX_WALLS))
  `NWD_ASSERT(a_div_rem, state == S_DIV, rem < len2[33:0])
  `NWD_ASSERT_NEXT(a_reject_full, accept && in_ch.mode == MODE_ADD && full, res_rej == 1'b1)
endmodule
